[src/sws_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sws_pkg
// shared constants and types of the signed word sorter
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int DEPTH_DEF   = 64;  // default element store depth
  localparam int VALUE_W     = 32;  // element width
  localparam int STACK_DEPTH = 7;   // pending sub-range entries

  typedef enum logic [3:0] {
    S_IDLE,    // loading, takes beats
    S_POP,     // pop next pending range
    S_RANGE,   // check range, fetch pivot
    S_PIVOT,   // latch pivot
    S_READ,    // fetch element j and element at store point
    S_CMP,     // compare against pivot, first half of swap
    S_SWAP,    // second half of swap
    S_FINAL,   // pivot into store point, first half
    S_FSWAP,   // pivot swap, second half
    S_SPLIT,   // choose sides, push larger part
    S_EMIT     // stream sorted store out
  } sws_state_t;

endpackage : sws_pkg
`default_nettype wire

[src/sws_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sws_store
// element store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module sws_store #(
  parameter int DEPTH = sws_pkg::DEPTH_DEF,
  parameter int WIDTH = sws_pkg::VALUE_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data shows the old word on a same-cycle write
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule : sws_store
`default_nettype wire

[src/signed_word_sorter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// signed_word_sorter
// collects signed 32-bit words into a store and, on the last beat of a set,
// sorts the store in place (lomuto partition quicksort) and streams it out
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | flow control
//  ---------+-----------------------------------------+----------------------
//  input    | start, busy, in_value, in_last          | taken: start & !busy
//  result   | out_strobe, out_value_res, out_last_res,| one cycle per beat,
//           | out_overflow                            | never held off
//  config   | cfg_we, cfg_data                        | written on cfg_we
//
// loading takes one beat per cycle. the sort runs on the single store with
// one write port: every compare step is a read then a compare, a swap adds
// a second write, and each range adds pop, range, pivot, final, pivot-swap
// and split steps. the whole set is sorted before it is streamed out.
// reset (rst_n low, synchronous) empties the store and clears the overflow
// flag and the mode. busy stays high from the cycle after a last beat until
// the final result has been read from the store.
// ----------------------------------------------------------------------------
module signed_word_sorter #(
  parameter int DEPTH = sws_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [sws_pkg::VALUE_W-1:0]  in_value,
  input  wire logic                                in_last,
  // result channel
  output logic                                     out_strobe,
  output logic signed      [sws_pkg::VALUE_W-1:0]  out_value_res,
  output logic                                     out_last_res,
  output logic                                     out_overflow,
  // mode register
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_data
);

  localparam int VW  = sws_pkg::VALUE_W;
  localparam int IW  = $clog2(DEPTH);              // store index
  localparam int CW  = $clog2(DEPTH + 1);          // fill count
  localparam int SW  = IW + 2;                     // signed working index
  localparam int SD  = sws_pkg::STACK_DEPTH;
  localparam int SPW = $clog2(SD + 1);             // stack pointer
  localparam int SIW = $clog2(SD);                 // stack index
  localparam logic [CW-1:0]  DEPTH_C = CW'(DEPTH);
  localparam logic [SPW-1:0] SD_C    = SPW'(SD);

  typedef struct packed {
    logic [IW-1:0] lo;
    logic [IW-1:0] hi;
  } range_t;

  // control state
  sws_pkg::sws_state_t state_r, state_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic                ovf_r, ovf_nxt;
  logic                desc_r, desc_nxt;
  logic [SPW-1:0]      sp_r, sp_nxt;
  logic                strobe_r, strobe_nxt;

  // working registers
  logic signed [SW-1:0] lo_r, lo_nxt;
  logic signed [SW-1:0] hi_r, hi_nxt;
  logic [IW-1:0]        j_r, j_nxt;
  logic [IW-1:0]        st_r, st_nxt;
  logic signed [VW-1:0] pivot_r, pivot_nxt;
  logic [VW-1:0]        tmp_r, tmp_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic                 olast_r, olast_nxt;
  logic                 oovf_r, oovf_nxt;
  range_t               stack_r [SD];
  logic                 push;
  logic [SIW-1:0]       push_idx;
  range_t               push_rng;

  // store ports
  logic          m_we;
  logic [IW-1:0] m_waddr;
  logic [VW-1:0] m_wdata;
  logic [IW-1:0] m_raddr_a, m_raddr_b;
  logic [VW-1:0] m_rdata_a, m_rdata_b;

  // decode helpers
  logic                 accept;
  logic                 room;
  logic [CW-1:0]        cnt_new;
  logic [SPW-1:0]       sp_m1;
  range_t               top_rng;
  logic signed [VW-1:0] elem_a;
  logic                 goes_left;
  logic signed [SW-1:0] p_s, lsz, rsz, plo, phi;
  logic                 range_ok, j_in, emit_end;

  sws_store #(
    .DEPTH (DEPTH),
    .WIDTH (VW)
  ) u_store (
    .clk     (clk),
    .we      (m_we),
    .waddr   (m_waddr),
    .wdata   (m_wdata),
    .raddr_a (m_raddr_a),
    .raddr_b (m_raddr_b),
    .rdata_a (m_rdata_a),
    .rdata_b (m_rdata_b)
  );

  assign accept   = start && (state_r == sws_pkg::S_IDLE);
  assign room     = fill_r < DEPTH_C;
  assign cnt_new  = room ? fill_r + CW'(1) : fill_r;
  assign sp_m1    = sp_r - SPW'(1);
  assign top_rng  = stack_r[sp_m1[SIW-1:0]];
  assign elem_a   = $signed(m_rdata_a);
  // element goes left of the pivot
  assign goes_left = desc_r ? (pivot_r < elem_a) : (elem_a < pivot_r);
  assign range_ok = lo_r < hi_r;
  assign j_in     = $signed({2'b00, j_r}) < hi_r;
  assign emit_end = k_r == (fill_r - CW'(1));

  // partition sizes around the pivot, smaller side is worked next
  assign p_s = $signed({2'b00, st_r});
  assign lsz = p_s - lo_r;
  assign rsz = hi_r - p_s;
  assign plo = (lsz < rsz) ? p_s + SW'(1) : lo_r;
  assign phi = (lsz < rsz) ? hi_r : p_s - SW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sws_pkg::S_IDLE: begin
        if (accept && in_last) begin
          state_nxt = (cnt_new > CW'(1)) ? sws_pkg::S_POP : sws_pkg::S_EMIT;
        end
      end
      sws_pkg::S_POP:   state_nxt = (sp_r == '0) ? sws_pkg::S_EMIT : sws_pkg::S_RANGE;
      sws_pkg::S_RANGE: state_nxt = range_ok ? sws_pkg::S_PIVOT : sws_pkg::S_POP;
      sws_pkg::S_PIVOT: state_nxt = sws_pkg::S_READ;
      sws_pkg::S_READ:  state_nxt = j_in ? sws_pkg::S_CMP : sws_pkg::S_FINAL;
      sws_pkg::S_CMP:   state_nxt = goes_left ? sws_pkg::S_SWAP : sws_pkg::S_READ;
      sws_pkg::S_SWAP:  state_nxt = sws_pkg::S_READ;
      sws_pkg::S_FINAL: state_nxt = sws_pkg::S_FSWAP;
      sws_pkg::S_FSWAP: state_nxt = sws_pkg::S_SPLIT;
      sws_pkg::S_SPLIT: state_nxt = sws_pkg::S_RANGE;
      sws_pkg::S_EMIT:  state_nxt = emit_end ? sws_pkg::S_IDLE : sws_pkg::S_EMIT;
      default:          state_nxt = sws_pkg::S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    fill_nxt   = fill_r;
    ovf_nxt    = ovf_r;
    desc_nxt   = cfg_we ? cfg_data : desc_r;
    sp_nxt     = sp_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    j_nxt      = j_r;
    st_nxt     = st_r;
    pivot_nxt  = pivot_r;
    tmp_nxt    = tmp_r;
    k_nxt      = k_r;
    strobe_nxt = 1'b0;
    olast_nxt  = olast_r;
    oovf_nxt   = oovf_r;
    push       = 1'b0;
    push_idx   = sp_r[SIW-1:0];
    push_rng   = '{lo: plo[IW-1:0], hi: phi[IW-1:0]};
    m_we       = 1'b0;
    m_waddr    = '0;
    m_wdata    = '0;
    m_raddr_a  = '0;
    m_raddr_b  = '0;
    unique case (state_r)
      sws_pkg::S_IDLE: begin
        if (accept) begin
          if (room) begin
            m_we     = 1'b1;
            m_waddr  = fill_r[IW-1:0];
            m_wdata  = in_value;
            fill_nxt = cnt_new;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            k_nxt = '0;
            if (cnt_new > CW'(1)) begin
              // whole set as the first pending range
              push     = 1'b1;
              push_idx = '0;
              push_rng = '{lo: '0, hi: IW'(cnt_new - CW'(1))};
              sp_nxt   = SPW'(1);
            end
          end
        end
      end
      sws_pkg::S_POP: begin
        if (sp_r != '0) begin
          sp_nxt = sp_m1;
          lo_nxt = $signed({2'b00, top_rng.lo});
          hi_nxt = $signed({2'b00, top_rng.hi});
        end
      end
      sws_pkg::S_RANGE: begin
        m_raddr_a = hi_r[IW-1:0];
      end
      sws_pkg::S_PIVOT: begin
        pivot_nxt = elem_a;
        j_nxt     = lo_r[IW-1:0];
        st_nxt    = lo_r[IW-1:0];
      end
      sws_pkg::S_READ: begin
        m_raddr_a = j_r;
        m_raddr_b = st_r;
      end
      sws_pkg::S_CMP: begin
        if (goes_left) begin
          m_we    = 1'b1;
          m_waddr = st_r;
          m_wdata = m_rdata_a;
          tmp_nxt = m_rdata_b;
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      sws_pkg::S_SWAP: begin
        m_we    = 1'b1;
        m_waddr = j_r;
        m_wdata = tmp_r;
        st_nxt  = st_r + IW'(1);
        j_nxt   = j_r + IW'(1);
      end
      sws_pkg::S_FINAL: begin
        m_we    = 1'b1;
        m_waddr = st_r;
        m_wdata = pivot_r;
        tmp_nxt = m_rdata_b;
      end
      sws_pkg::S_FSWAP: begin
        m_we    = 1'b1;
        m_waddr = hi_r[IW-1:0];
        m_wdata = tmp_r;
      end
      sws_pkg::S_SPLIT: begin
        if (lsz < rsz) begin
          hi_nxt = p_s - SW'(1);
        end else begin
          lo_nxt = p_s + SW'(1);
        end
        // larger side waits on the stack if it holds two or more elements and the stack is not full
        if ((plo < phi) && (sp_r < SD_C)) begin
          push   = 1'b1;
          sp_nxt = sp_r + SPW'(1);
        end
      end
      sws_pkg::S_EMIT: begin
        m_raddr_a  = k_r[IW-1:0];
        strobe_nxt = 1'b1;
        olast_nxt  = emit_end;
        oovf_nxt   = ovf_r;
        k_nxt      = k_r + CW'(1);
        if (emit_end) begin
          fill_nxt = '0;
          ovf_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sws_pkg::S_IDLE;
      fill_r   <= '0;
      ovf_r    <= 1'b0;
      desc_r   <= 1'b0;
      sp_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      ovf_r    <= ovf_nxt;
      desc_r   <= desc_nxt;
      sp_r     <= sp_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    j_r     <= j_nxt;
    st_r    <= st_nxt;
    pivot_r <= pivot_nxt;
    tmp_r   <= tmp_nxt;
    k_r     <= k_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
    if (push) begin
      stack_r[push_idx] <= push_rng;
    end
  end

  // result beat: store read data lines up with the strobe
  assign busy          = state_r != sws_pkg::S_IDLE;
  assign out_strobe    = strobe_r;
  assign out_value_res = $signed(m_rdata_a);
  assign out_last_res  = olast_r;
  assign out_overflow  = oovf_r;

endmodule : signed_word_sorter
`default_nettype wire
